// ===== sv/cic_pkg.sv =====
// Shared constants and types of the CIC decimator.
// Used by the interfaces, the front, queue, back and top-level modules.
`default_nettype none

package cic_pkg;

  // Filter structure
  localparam int STAGES    = 4;
  localparam int MAX_DELAY = 2;
  localparam int ACC_WIDTH = 48;

  // Port widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int OUT_WIDTH    = 48;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  // Configuration register indexes and widths
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_DELAY = CFG_IDX_W'(1);
  localparam int RATE_W    = 13;
  localparam int PHASE_W   = 12;
  localparam int R_MAX     = 4096;
  localparam int DLYREG_W  = 2;
  localparam logic [RATE_W-1:0]   RATE_RESET  = RATE_W'(8);
  localparam logic [DLYREG_W-1:0] DELAY_RESET = DLYREG_W'(1);

  // Comb delay slot pointer
  localparam int PTR_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CNT_W = PTR_W + 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ACC_WIDTH-1:0] acc_t;

  // Effective settings handed from the register file to the datapath
  typedef struct packed {
    logic [RATE_W-1:0] rate;   // R, 1..R_MAX
    logic [CNT_W-1:0]  delay;  // M, 1..MAX_DELAY
  } cic_cfg_t;

  // Queue handshake seen from the producer side
  typedef struct packed {
    logic valid;
    acc_t data;
  } cic_push_t;

endpackage

`default_nettype wire

// ===== sv/cic_if.sv =====
// Stream interfaces of the CIC decimator: input samples, filter results
// and configuration writes. Depends on cic_pkg.
`default_nettype none

interface cic_sample_if import cic_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface cic_result_if import cic_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] filtered;
  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

interface cic_cfg_if import cic_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/cic_decimator_top.sv =====
// CIC decimator, top level: configuration registers, integrator front,
// queue and comb back. Depends on cic_pkg, cic_if, cic_front, cic_queue, cic_back.
//
// Usage:
//   samples : valid/ready stream of signed 16-bit input samples; a
//             transaction is taken whenever valid and ready are high.
//   results : valid/ready stream of signed 48-bit filter outputs, one for
//             every R accepted samples.
//   cfg     : write channel, index 0 = decimation factor R (13 bits),
//             index 1 = differential delay M (2 bits); always ready.
//             Write only while the filter is empty.
// Throughput: one sample per clock while no receiver stall backs up to the
// input. The four-stage integrator and comb pipelines each do one wide add
// or subtract per stage per cycle. A block-closing sample passes through
// integrator stages 0 to 3, a queue entry and comb stages 0 to 3 before it
// shows up on results.
// Reset (rst, synchronous): clears all sums, comb delays, the phase
// counter and slot pointer; R returns to 8 and M to 1.
// Receiver stall: results hold; the comb pipeline and a two-entry queue
// absorb outputs, and samples that do not close a block keep flowing until
// a block-closing sample finds the queue full.
`default_nettype none

module cic_decimator_top import cic_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  cic_sample_if.sink  samples,
  cic_result_if.source results,
  cic_cfg_if.sink     cfg
);

  logic [RATE_W-1:0]   decimation_factor;
  logic [DLYREG_W-1:0] differential_delay;
  cic_cfg_t            eff;
  cic_push_t           push;
  logic                push_ready;
  logic                q_valid;
  logic                q_ready;
  acc_t                q_data;

  assign cfg.ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decimation_factor  <= RATE_RESET;
      differential_delay <= DELAY_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DECIMATION: decimation_factor  <= cfg.data[RATE_W-1:0];
        REG_DIFF_DELAY: differential_delay <= cfg.data[DLYREG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp R and M to their legal ranges
  always_comb begin
    if (decimation_factor == '0) begin
      eff.rate = RATE_W'(1);
    end else if (32'(decimation_factor) > R_MAX) begin
      eff.rate = RATE_W'(R_MAX);
    end else begin
      eff.rate = decimation_factor;
    end
    if (differential_delay == '0) begin
      eff.delay = CNT_W'(1);
    end else if (32'(differential_delay) > MAX_DELAY) begin
      eff.delay = CNT_W'(MAX_DELAY);
    end else begin
      eff.delay = CNT_W'(differential_delay);
    end
  end

  cic_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (eff),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .in_sample  (samples.sample),
    .push       (push),
    .push_ready (push_ready)
  );

  cic_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  cic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (eff),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (q_data),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.filtered)
  );

endmodule

`default_nettype wire

// ===== sv/cic_front.sv =====
// Front part: pipelined integrator chain and decimation phase counter.
// Tags each sample that closes a block and forwards only those. Uses cic_pkg.
`default_nettype none

module cic_front import cic_pkg::*; (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cic_cfg_t                       cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output cic_push_t                           push,
  input  wire logic                           push_ready
);

  // Each stage register is both the running sum and the value passed on
  acc_t             sum   [STAGES];
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] flg;
  logic [STAGES-1:0] can_load;
  logic [STAGES-1:0] leave;
  logic [STAGES-1:0] load;
  logic [PHASE_W-1:0] phase;
  logic [RATE_W-1:0]  phase_inc;
  logic               block_end;
  acc_t               x_ext;

  // Resolve the stage handshakes from the last stage backwards
  always_comb begin
    for (int i = STAGES - 1; i >= 0; i--) begin
      if (i == STAGES - 1) begin
        leave[i] = vld[i] & (~flg[i] | push_ready);
      end else begin
        leave[i] = vld[i] & can_load[i+1];
      end
      can_load[i] = ~vld[i] | leave[i];
    end
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        load[i] = in_valid & can_load[0];
      end else begin
        load[i] = leave[i-1];
      end
    end
  end

  assign in_ready  = can_load[0];
  assign x_ext     = ACC_WIDTH'(in_sample);
  assign phase_inc = {1'b0, phase} + RATE_W'(1);
  assign block_end = (phase_inc >= cfg.rate);

  // Count samples within the current block
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (load[0]) begin
      phase <= block_end ? '0 : phase_inc[PHASE_W-1:0];
    end
  end

  // Advance valid and block-end tags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      flg <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        vld[i] <= load[i] | (vld[i] & ~leave[i]);
        if (load[i]) begin
          flg[i] <= (i == 0) ? block_end : flg[i-1];
        end
      end
    end
  end

  // Accumulate on each transaction entering a stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        sum[i] <= '0;
      end
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (load[i]) begin
          sum[i] <= sum[i] + ((i == 0) ? x_ext : sum[i-1]);
        end
      end
    end
  end

  // Forward only block-closing sums
  assign push.valid = vld[STAGES-1] & flg[STAGES-1];
  assign push.data  = sum[STAGES-1];

endmodule

`default_nettype wire

// ===== sv/cic_queue.sv =====
// Short queue between the integrator front and the comb back.
// Holds decimated integrator sums. Uses cic_pkg.
`default_nettype none

module cic_queue import cic_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cic_push_t push,
  output logic           push_ready,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output acc_t           pop_data
);

  acc_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr;
  logic [QPTR_W-1:0]  rptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push.valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;
  assign pop_data   = mem[rptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push.data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      if (do_push & ~do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop & ~do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/cic_back.sv =====
// Back part: pipelined comb chain with per-stage delay rows.
// Each transaction carries its delay slot pointer down the chain. Uses cic_pkg.
`default_nettype none

module cic_back import cic_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cic_cfg_t             cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire acc_t                 in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [OUT_WIDTH-1:0] out_data
);

  acc_t              val  [STAGES];
  acc_t              dly  [STAGES][MAX_DELAY];
  logic [PTR_W-1:0]  slot [STAGES];
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] can_load;
  logic [STAGES-1:0] leave;
  logic [STAGES-1:0] load;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  ptr_next;
  logic [CNT_W-1:0]  ptr_inc;

  // Resolve stage handshakes from the output backwards
  always_comb begin
    for (int j = STAGES - 1; j >= 0; j--) begin
      if (j == STAGES - 1) begin
        leave[j] = vld[j] & out_ready;
      end else begin
        leave[j] = vld[j] & can_load[j+1];
      end
      can_load[j] = ~vld[j] | leave[j];
    end
    for (int j = 0; j < STAGES; j++) begin
      if (j == 0) begin
        load[j] = in_valid & can_load[0];
      end else begin
        load[j] = leave[j-1];
      end
    end
  end

  assign in_ready = can_load[0];

  // Step the shared slot pointer, wrapping at M
  assign ptr_inc  = {1'b0, ptr} + CNT_W'(1);
  assign ptr_next = (ptr_inc >= cfg.delay) ? '0 : ptr_inc[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (load[0]) begin
      ptr <= ptr_next;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int j = 0; j < STAGES; j++) begin
        vld[j] <= load[j] | (vld[j] & ~leave[j]);
      end
    end
  end

  // Carry payload and slot index down the chain
  always_ff @(posedge clk) begin
    for (int j = 0; j < STAGES; j++) begin
      if (load[j]) begin
        if (j == 0) begin
          val[j]  <= in_data - dly[j][ptr_next];
          slot[j] <= ptr_next;
        end else begin
          val[j]  <= val[j-1] - dly[j][slot[j-1]];
          slot[j] <= slot[j-1];
        end
      end
    end
  end

  // Replace the delayed comb input in each row
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < STAGES; j++) begin
        for (int k = 0; k < MAX_DELAY; k++) begin
          dly[j][k] <= '0;
        end
      end
    end else begin
      for (int j = 0; j < STAGES; j++) begin
        if (load[j]) begin
          if (j == 0) begin
            dly[j][ptr_next] <= in_data;
          end else begin
            dly[j][slot[j-1]] <= val[j-1];
          end
        end
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_data  = OUT_WIDTH'(val[STAGES-1]);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for cic_decimator_top: drives sample, result and register channels.
// Predicts filter outputs with a 48-bit wrapping integrator/comb model.
// Depends on cic_pkg, cic_if and the decimator RTL.
`timescale 1ns / 100ps

module tb;
  import cic_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int TAIL_CYCLES = 12;

  logic clk;
  logic rst;

  cic_sample_if sample_ch ();
  cic_result_if result_ch ();
  cic_cfg_if    cfg_ch ();

  cic_decimator_top dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  // Predicted filter state and register copies
  acc_t              integ_sum [STAGES];
  acc_t              comb_hist [STAGES*MAX_DELAY];
  int unsigned       slot_ptr;
  int unsigned       block_phase;
  logic [RATE_W-1:0] rate_reg;
  logic [DLYREG_W-1:0] delay_reg;

  logic signed [SAMPLE_WIDTH-1:0] sample_backlog [$];
  logic signed [OUT_WIDTH-1:0]    pending_outputs [$];

  int   error_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_request;
  int   stall_left;
  logic sample_taken;

  // Run one accepted sample through the integrators and, at block end, the combs
  function automatic void filter_sample(logic signed [SAMPLE_WIDTH-1:0] s);
    acc_t        v;
    acc_t        old;
    int unsigned r;
    int unsigned m;
    int unsigned slot;
    v = {{(ACC_WIDTH-SAMPLE_WIDTH){s[SAMPLE_WIDTH-1]}}, s};
    for (int i = 0; i < STAGES; i++) begin
      integ_sum[i] = integ_sum[i] + v;
      v = integ_sum[i];
    end
    r = (rate_reg == 0) ? 1 : ((rate_reg > R_MAX) ? R_MAX : rate_reg);
    if (block_phase + 1 < r) begin
      block_phase++;
      return;
    end
    block_phase = 0;
    m = (delay_reg == 0) ? 1 : ((delay_reg > MAX_DELAY) ? MAX_DELAY : delay_reg);
    slot_ptr++;
    if (slot_ptr >= m) slot_ptr = 0;
    for (int i = 0; i < STAGES; i++) begin
      slot = i * MAX_DELAY + slot_ptr;
      old = comb_hist[slot];
      comb_hist[slot] = v;
      v = v - old;
    end
    pending_outputs.push_back(v[OUT_WIDTH-1:0]);
  endfunction

  // Mix of extremes, near-zero values and full-range noise
  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    int unsigned sel;
    logic [31:0] raw;
    sel = $urandom_range(9);
    raw = $urandom;
    case (sel)
      0: pick_sample = 16'sh7FFF;
      1: pick_sample = 16'sh8000;
      2: pick_sample = SAMPLE_WIDTH'($signed($urandom_range(8)) - 4);
      default: pick_sample = raw[SAMPLE_WIDTH-1:0];
    endcase
  endfunction

  // Clock
  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Sample driver: hold an offered transaction until taken, else maybe idle
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!(sample_ch.valid && !sample_taken)) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= sample_backlog[0];
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure plus an occasional long hold-off
  always @(negedge clk) begin
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: track register writes, predict on each sample, check each result
  always @(posedge clk) begin
    logic signed [OUT_WIDTH-1:0] want;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DECIMATION: rate_reg = cfg_ch.data[RATE_W-1:0];
          REG_DIFF_DELAY: delay_reg = cfg_ch.data[DLYREG_W-1:0];
          default: ;
        endcase
      end
      if (sample_ch.valid && sample_ch.ready) begin
        filter_sample(sample_ch.sample);
        void'(sample_backlog.pop_front());
        sample_taken <= 1'b1;
      end else begin
        sample_taken <= 1'b0;
      end
      if (result_ch.valid && result_ch.ready) begin
        if (pending_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d",
                   $time, result_ch.filtered);
          error_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (result_ch.filtered !== want) begin
            $display("%0t: filtered mismatch, expected %0d, got %0d",
                     $time, want, result_ch.filtered);
            error_count++;
          end
        end
      end
    end
  end

  // Write one register and wait for the transaction
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] word);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= word;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every queued sample is taken and every result has arrived
  task automatic drain();
    while (sample_backlog.size() != 0 || pending_outputs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] rate_word,
                           input logic [CFG_DATA_W-1:0] delay_word,
                           input int n_items, input int send_pct,
                           input int recv_pct, input int stall_len);
    write_register(REG_DECIMATION, rate_word);
    write_register(REG_DIFF_DELAY, delay_word);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n_items; i++) sample_backlog.push_back(pick_sample());
    if (stall_len != 0) stall_request = stall_len;
    drain();
  endtask

  // Stimulus sequence
  initial begin
    logic signed [SAMPLE_WIDTH-1:0] directed [$];
    directed = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF,
                 16'sh8000, 16'sh5555, 16'shAAAA, 16'sh0000, 16'sh8000, 16'sh7FFF,
                 16'sh8000, 16'sh7FFF, 16'sh00FF, 16'shFF00, 16'shFFFF, 16'sh0001};
    rst             = 1'b1;
    error_count     = 0;
    send_idle_pct   = 14;
    recv_idle_pct   = 54;
    stall_request   = 0;
    stall_left      = 0;
    sample_taken    = 1'b0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    rate_reg    = RATE_RESET;
    delay_reg   = DELAY_RESET;
    slot_ptr    = 0;
    block_phase = 0;
    for (int i = 0; i < STAGES; i++) integ_sum[i] = '0;
    for (int i = 0; i < STAGES*MAX_DELAY; i++) comb_hist[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes at the reset settings (R = 8, M = 1)
    @(posedge clk);
    foreach (directed[i]) sample_backlog.push_back(directed[i]);
    drain();

    // Sender light, receiver heavy idling
    run_phase(16'h0000, 16'h0002, 80, 14, 54, 0);    // zero R acts as one
    run_phase(16'h0002, 16'h0003, 120, 14, 54, 0);   // M above max saturates
    run_phase(16'h0005, 16'h0000, 120, 14, 54, 0);   // zero M acts as one
    // Sender heavy, receiver light idling
    run_phase(16'hFFFF, 16'h0002, 150, 54, 14, 0);   // R saturates, block stays open
    run_phase(16'h0010, 16'h0001, 150, 54, 14, 0);   // open block closes at once
    run_phase(16'h0007, 16'hFFFE, 150, 54, 14, 0);
    // No idling; long receiver hold-off fills the pipe and stalls input
    run_phase(16'h0001, 16'h0002, 250, 0, 0, 300);
    run_phase(16'h0004, 16'h0001, 150, 0, 0, 0);
    run_phase(16'h2003, 16'h0001, 120, 0, 0, 0);
    run_phase(16'h0000, 16'h0003, 80, 0, 0, 0);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
